### sv/stt_pkg.sv
`timescale 1ns / 1ps

package stt_pkg;

  localparam int POS_BITS_DEF = 16;

  // Result queue between the scanner and the output port.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_INT   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;

  localparam logic [3:0] TAG_ERROR  = 4'd0;
  localparam logic [3:0] TAG_EOF    = 4'd1;
  localparam logic [3:0] TAG_IDENT  = 4'd2;
  localparam logic [3:0] TAG_INT    = 4'd3;
  localparam logic [3:0] TAG_LPAREN = 4'd4;
  localparam logic [3:0] TAG_RPAREN = 4'd5;
  localparam logic [3:0] TAG_LCURLY = 4'd6;
  localparam logic [3:0] TAG_RCURLY = 4'd7;
  localparam logic [3:0] TAG_COLON  = 4'd8;
  localparam logic [3:0] TAG_SEMI   = 4'd9;
  localparam logic [3:0] TAG_COMMA  = 4'd10;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_LCURLY     = 8'h7B;
  localparam logic [7:0] CH_RCURLY     = 8'h7D;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_TAB        = 8'h09;

  typedef struct packed {
    logic [3:0]         tag;
    logic signed [16:0] start;
    logic [15:0]        stop;
    logic               last;
  } stt_tok_t;

  // Tokens produced by one input transaction, at most two.
  typedef struct packed {
    logic [1:0] cnt;
    stt_tok_t   first;
    stt_tok_t   second;
  } stt_push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, CH_NEWLINE, CH_TAB};
  endfunction

  function automatic logic [3:0] mark_tag(input logic [7:0] c);
    logic [3:0] t;
    case (c)
      CH_LPAREN: t = TAG_LPAREN;
      CH_RPAREN: t = TAG_RPAREN;
      CH_LCURLY: t = TAG_LCURLY;
      CH_RCURLY: t = TAG_RCURLY;
      CH_COLON:  t = TAG_COLON;
      CH_SEMI:   t = TAG_SEMI;
      CH_COMMA:  t = TAG_COMMA;
      default:   t = TAG_ERROR;
    endcase
    return t;
  endfunction

endpackage

### sv/stt_scan.sv
`timescale 1ns / 1ps

module stt_scan import stt_pkg::*; #(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_op,
  input  logic [7:0] in_char_byte,
  input  logic       room,
  output logic       in_stall,
  output stt_push_t  push
);

  localparam int SW = (POSITION_BITS > 17) ? POSITION_BITS : 17;
  localparam int EW = (POSITION_BITS > 16) ? POSITION_BITS : 16;

  logic                     valid_r, valid_nxt;
  logic                     op_r;
  logic [7:0]               char_r;
  logic [1:0]               mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pstart_r, pstart_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;

  logic                     adv;
  logic                     c_digit, c_alpha, c_space;
  logic [1:0]               mode_eff;
  logic                     flush, single;
  logic [3:0]               flush_tag, single_tag;
  logic signed [16:0]       single_start;
  logic [15:0]              single_stop;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [SW-1:0]            pos_m1;
  stt_tok_t                 tok0, tok1;

  function automatic logic signed [16:0] to_start(input logic [POSITION_BITS-1:0] v);
    logic [SW-1:0] w;
    w = SW'(v);
    return $signed(w[16:0]);
  endfunction

  function automatic logic [15:0] to_end(input logic [POSITION_BITS-1:0] v);
    logic [EW-1:0] w;
    w = EW'(v);
    return w[15:0];
  endfunction

  assign adv      = valid_r && room;
  assign in_stall = valid_r && !room;

  assign pos_inc = (&pos_r) ? pos_r : pos_r + POSITION_BITS'(1);
  // The end-of-file start wraps to all ones for an empty source.
  assign pos_m1  = SW'(pos_r) - SW'(1);

  always_comb begin
    c_digit      = is_digit(char_r);
    c_alpha      = is_letter(char_r);
    c_space      = is_space(char_r);
    flush        = 1'b0;
    flush_tag    = TAG_INT;
    mode_eff     = mode_r;
    single       = 1'b0;
    single_tag   = TAG_EOF;
    single_start = $signed(pos_m1[16:0]);
    single_stop  = to_end(pos_r);
    pstart_nxt   = pstart_r;
    pos_nxt      = pos_r;

    case (mode_r)
      MODE_INT: begin
        if (op_r || !c_digit) begin
          flush     = 1'b1;
          flush_tag = TAG_INT;
          mode_eff  = MODE_IDLE;
        end
      end
      MODE_IDENT: begin
        if (op_r || !(c_digit || c_alpha)) begin
          flush     = 1'b1;
          flush_tag = TAG_IDENT;
          mode_eff  = MODE_IDLE;
        end
      end
      MODE_IDLE: ;
      default: mode_eff = MODE_IDLE;
    endcase

    mode_nxt = mode_eff;
    if (op_r) begin
      single = 1'b1;
    end else begin
      if (mode_eff == MODE_IDLE) begin
        if (c_digit) begin
          mode_nxt   = MODE_INT;
          pstart_nxt = pos_r;
        end else if (c_alpha) begin
          mode_nxt   = MODE_IDENT;
          pstart_nxt = pos_r;
        end else if (!c_space) begin
          single       = 1'b1;
          single_tag   = mark_tag(char_r);
          single_start = to_start(pos_r);
          single_stop  = to_end(pos_inc);
        end
      end
      pos_nxt = pos_inc;
    end
  end

  always_comb begin
    tok0.tag   = flush_tag;
    tok0.start = to_start(pstart_r);
    tok0.stop  = to_end(pos_r);
    tok0.last  = !single;
    tok1.tag   = single_tag;
    tok1.start = single_start;
    tok1.stop  = single_stop;
    tok1.last  = 1'b1;

    push.cnt    = adv ? {flush & single, flush ^ single} : 2'd0;
    push.first  = flush ? tok0 : tok1;
    push.second = tok1;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && !in_stall) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      mode_r   <= MODE_IDLE;
      pstart_r <= '0;
      pos_r    <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (adv) begin
        mode_r   <= mode_nxt;
        pstart_r <= pstart_nxt;
        pos_r    <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r   <= in_op;
      char_r <= in_char_byte;
    end
  end

endmodule

### sv/stt_result_fifo.sv
`timescale 1ns / 1ps

module stt_result_fifo import stt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  stt_push_t          push,
  input  logic               pop,
  output logic [LEVEL_W-1:0] level,
  output stt_tok_t           head
);

  stt_tok_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [LEVEL_W-1:0]     level_r, level_nxt;

  assign level = level_r;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    level_nxt  = level_r + LEVEL_W'(push.cnt) - LEVEL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + FIFO_AW'(1)] <= push.second;
    end
  end

endmodule

### sv/source_text_tokenizer_core.sv
`timescale 1ns / 1ps
// Channel  | Ports                                            | Direction
// ---------+--------------------------------------------------+----------
// input    | in_valid, in_stall, in_op, in_char_byte          | in
// result   | out_valid, out_stall, out_tok_kind,              | out
//          | out_token_start, out_token_end, out_last_of_run  |
//
// One source byte or end marker is accepted per cycle while in_stall is low; it
// is held in the input register, then the scan logic pushes zero, one or two
// tokens into a four-entry result queue. An item that flushes a pending token
// and also gives a token of its own pushes two tokens, which leave one per pop,
// so the output sets the rate then. Results go via the input register and queue.
// Reset is synchronous and clears the scanner state and the queue.
// in_stall rises while the input register holds a transaction and the queue has
// fewer than two free entries.

module source_text_tokenizer_core import stt_pkg::*; #(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [7:0]         in_char_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_tok_kind,
  output logic signed [16:0] out_token_start,
  output logic [15:0]        out_token_end,
  output logic               out_last_of_run
);

  stt_push_t          push;
  stt_tok_t           head;
  logic [LEVEL_W-1:0] level;
  logic               room;
  logic               pop;

  assign room = level <= LEVEL_W'(FIFO_DEPTH - 2);
  assign out_valid = level != '0;
  assign pop = out_valid && !out_stall;

  assign out_tok_kind    = head.tag;
  assign out_token_start = head.start;
  assign out_token_end   = head.stop;
  assign out_last_of_run = head.last;

  stt_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_op        (in_op),
    .in_char_byte (in_char_byte),
    .room         (room),
    .in_stall     (in_stall),
    .push         (push)
  );

  stt_result_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .level (level),
    .head  (head)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= LEVEL_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> !push.first.last && push.second.last &&
      (push.first.tag == TAG_INT || push.first.tag == TAG_IDENT))
    else $error("token pair is not a flushed run followed by a final token");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tok_kind == TAG_EOF |-> out_last_of_run)
    else $error("end-of-file token not marked last");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> level == '0)
    else $error("result queue not empty after reset");

endmodule

### verif/source_text_tokenizer_core_tb.sv
`timescale 1ns / 1ps

module source_text_tokenizer_core_tb;
  import stt_pkg::*;

  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TOP      = 8'hFF;
  localparam logic       OP_BYTE     = 1'b0;
  localparam logic       OP_END      = 1'b1;
  localparam logic [15:0] POS_TOP    = 16'hFFFF;
  localparam int         IDLE_LIMIT  = 5000;
  localparam int         RANDOM_ITEMS = 1650;

  // Tracks the scanner state and the tokens each accepted transaction should produce.
  class token_tracker;
    stt_tok_t    expected_tokens[$];
    logic [1:0]  scan_state;
    logic [15:0] word_start;
    logic [15:0] next_pos;
    int unsigned errors;

    function new();
      scan_state = MODE_IDLE;
      word_start = '0;
      next_pos   = '0;
      errors     = 0;
    endfunction

    function bit is_num(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit is_word(logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
             c == CH_UNDERSCORE;
    endfunction

    function bit is_gap(logic [7:0] c);
      return c == CH_SPACE || c == CH_NEWLINE || c == CH_TAB;
    endfunction

    function logic [3:0] mark_code(logic [7:0] c);
      case (c)
        CH_LPAREN: return TAG_LPAREN;
        CH_RPAREN: return TAG_RPAREN;
        CH_LCURLY: return TAG_LCURLY;
        CH_RCURLY: return TAG_RCURLY;
        CH_COLON:  return TAG_COLON;
        CH_SEMI:   return TAG_SEMI;
        CH_COMMA:  return TAG_COMMA;
        default:   return TAG_ERROR;
      endcase
    endfunction

    function logic [15:0] bump(logic [15:0] p);
      return (p == POS_TOP) ? p : p + 16'd1;
    endfunction

    function void add_token(logic [3:0] tag, logic signed [16:0] start, logic [15:0] stop);
      stt_tok_t t;
      t.tag   = tag;
      t.start = start;
      t.stop  = stop;
      t.last  = 1'b0;
      expected_tokens.push_back(t);
    endfunction

    function void scan_item(logic op, logic [7:0] c);
      int          n;
      logic [15:0] p;
      n = 0;
      p = next_pos;
      // A pending literal or identifier ends unless this byte extends it.
      if (scan_state == MODE_INT && !(op == OP_BYTE && is_num(c))) begin
        add_token(TAG_INT, {1'b0, word_start}, p);
        n++;
        scan_state = MODE_IDLE;
      end else if (scan_state == MODE_IDENT &&
                   !(op == OP_BYTE && (is_num(c) || is_word(c)))) begin
        add_token(TAG_IDENT, {1'b0, word_start}, p);
        n++;
        scan_state = MODE_IDLE;
      end
      if (op == OP_END) begin
        add_token(TAG_EOF, {1'b0, p} - 17'd1, p);
        n++;
      end else begin
        if (scan_state == MODE_IDLE) begin
          if (is_num(c)) begin
            scan_state = MODE_INT;
            word_start = p;
          end else if (is_word(c)) begin
            scan_state = MODE_IDENT;
            word_start = p;
          end else if (!is_gap(c)) begin
            add_token(mark_code(c), {1'b0, p}, bump(p));
            n++;
          end
        end
        next_pos = bump(p);
      end
      if (n > 0) expected_tokens[$].last = 1'b1;
    endfunction

    function void mismatch(string field, longint want, longint got);
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      errors++;
    endfunction

    function void compare_token(logic [3:0] tag, logic signed [16:0] start, logic [15:0] stop,
                                logic last);
      stt_tok_t want;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: tag %0d start %0d end %0d", tag, start, stop);
        errors++;
        return;
      end
      want = expected_tokens.pop_front();
      if (tag !== want.tag) mismatch("tok_kind", want.tag, tag);
      if (start !== want.start) mismatch("token_start", want.start, start);
      if (stop !== want.stop) mismatch("token_end", want.stop, stop);
      if (last !== want.last) mismatch("last_of_run", want.last, last);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_op = 1'b0;
  logic [7:0]         in_char_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         out_tok_kind;
  logic signed [16:0] out_token_start;
  logic [15:0]        out_token_end;
  logic               out_last_of_run;

  token_tracker board = new();
  int  burst_left = 0;
  int  idle_cycles = 0;

  source_text_tokenizer_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_char_byte    (in_char_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_tok_kind    (out_tok_kind),
    .out_token_start (out_token_start),
    .out_token_end   (out_token_end),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Presents one transaction and returns at the edge where it is accepted.
  task automatic offer(input logic op, input logic [7:0] c);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(7) == 0) repeat ($urandom_range(5, 20)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_char_byte <= c;
    do @(posedge clk); while (in_stall);
    board.scan_item(op, c);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic offer_text(input string s);
    for (int i = 0; i < s.len(); i++) offer(OP_BYTE, s[i]);
  endtask

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(52);
    if (r < 26) return 8'(CH_LOWER_A + r);
    if (r < 52) return 8'(CH_UPPER_A + (r - 26));
    return CH_UNDERSCORE;
  endfunction

  function automatic logic [7:0] pick_word_char();
    if ($urandom_range(3) == 0) return 8'(CH_ZERO + $urandom_range(9));
    return pick_letter();
  endfunction

  function automatic logic [7:0] pick_mark();
    logic [7:0] marks[7];
    marks = '{CH_LPAREN, CH_RPAREN, CH_LCURLY, CH_RCURLY, CH_COLON, CH_SEMI, CH_COMMA};
    return marks[$urandom_range(6)];
  endfunction

  function automatic logic [7:0] pick_gap();
    case ($urandom_range(2))
      0:       return CH_SPACE;
      1:       return CH_NEWLINE;
      default: return CH_TAB;
    endcase
  endfunction

  function automatic logic [7:0] pick_error();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (board.is_num(c) || board.is_word(c) || board.is_gap(c) ||
           board.mark_code(c) != TAG_ERROR)
      c = 8'($urandom_range(255));
    return c;
  endfunction

  // Mostly well-formed lexemes with random content, plus some noise and end markers.
  task automatic offer_random_token(inout int count);
    int kind;
    int len;
    kind = $urandom_range(99);
    if (kind < 25) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 6);
      offer(OP_BYTE, pick_letter());
      count++;
      repeat (len) begin
        offer(OP_BYTE, pick_word_char());
        count++;
      end
    end else if (kind < 45) begin
      repeat ($urandom_range(1, 6)) begin
        offer(OP_BYTE, 8'(CH_ZERO + $urandom_range(9)));
        count++;
      end
    end else if (kind < 65) begin
      offer(OP_BYTE, pick_mark());
      count++;
    end else if (kind < 80) begin
      repeat ($urandom_range(1, 3)) begin
        offer(OP_BYTE, pick_gap());
        count++;
      end
    end else if (kind < 85) begin
      offer(OP_BYTE, pick_error());
      count++;
    end else if (kind < 96) begin
      offer(OP_BYTE, 8'($urandom_range(255)));
      count++;
    end else begin
      offer(OP_END, 8'($urandom_range(255)));
      count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.compare_token(out_tok_kind, out_token_start, out_token_end, out_last_of_run);
  end

  // Receiver stalls in epochs of varying density, with two long hold-offs early in the run.
  initial begin
    int cyc;
    int pct;
    int epoch_left;
    cyc = 0;
    pct = 0;
    epoch_left = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (epoch_left == 0) begin
        case ($urandom_range(4))
          0, 1:    pct = 0;
          2:       pct = 20;
          3:       pct = 50;
          default: pct = 85;
        endcase
        epoch_left = $urandom_range(20, 200);
      end
      epoch_left--;
      if ((cyc >= 600 && cyc < 1000) || (cyc >= 2500 && cyc < 2800)) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(99) < pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int count;
    count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: end marker on empty source and repeated, both token kinds, every mark,
    // the zero byte, a top-bit byte, carriage return, and a flush followed by end of file.
    offer(OP_END, 8'hA5);
    offer(OP_END, CH_NUL);
    offer_text("Az_9 09a(");
    offer_text("){}:;,");
    offer(OP_BYTE, CH_NUL);
    offer(OP_BYTE, CH_TOP);
    offer(OP_BYTE, CH_CR);
    offer(OP_BYTE, CH_TAB);
    offer(OP_BYTE, CH_NEWLINE);
    offer_text("7");
    offer(OP_END, CH_UPPER_Z);
    offer(OP_END, CH_TOP);

    while (count < RANDOM_ITEMS) offer_random_token(count);

    // An identifier flushed by a mark, then an integer flushed by the end marker.
    offer_text("ab(9");
    offer(OP_END, 8'h3C);
    offer(OP_END, 8'hC3);

    in_valid <= 1'b0;
    while (board.expected_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (board.errors == 0 && board.expected_tokens.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/stt_pkg.sv
sv/stt_scan.sv
sv/stt_result_fifo.sv
sv/source_text_tokenizer_core.sv
verif/source_text_tokenizer_core_tb.sv
